FILE: rtl/core/central_window_downsampler_top_defines.svh
// assertion macros for the central window downsampler
// taken in by the controller and the datapath, no other dependencies
`ifndef CENTRAL_WINDOW_DOWNSAMPLER_TOP_DEFINES_SVH
`define CENTRAL_WINDOW_DOWNSAMPLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CWD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cwd assertion failed");
`define CWD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cwd assertion failed");
`else
`define CWD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CWD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/cwd_pkg.sv
// shared constants, types and command/status structs of the downsampler
// no dependencies
package cwd_pkg;

   localparam int MAX_OUT_WIDTH     = 128;
   localparam int MAX_SCALE_QUARTER = 8;
   localparam int MAX_OUT_HEIGHT    = 1024;

   localparam int GREEN_W = 8;
   localparam int GREY_W  = 8;
   localparam int K_W     = 4;
   localparam int OW_W    = 8;
   localparam int OH_W    = 11;
   localparam int COL_W   = $clog2(MAX_OUT_WIDTH);
   localparam int SUB_W   = 5;
   localparam int ROW_W   = 10;
   localparam int SUM_W   = 16;

   // sum / (4 k^2) is done as (sum >> 2) / k^2
   localparam int DIVD_W = SUM_W - 2;
   localparam int DIVS_W = 7;
   localparam int CNT_W  = $clog2(DIVD_W);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef struct packed {
      logic [K_W-1:0]  k;
      logic [OW_W-1:0] width;
      logic [OH_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic take;
      logic rd;
      logic wr_now;
      logic wr_read;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic in_win;
      logic direct;
      logic emit_now;
      logic emit_held;
      logic div_done;
      logic out_full;
   } sts_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_READ,
      ST_DIV
   } state_type;

endpackage

FILE: rtl/core/cwd_if.sv
// pixel and result channel interfaces of the downsampler
// depends on cwd_pkg for the payload widths
interface cwd_req_if;
   logic                        valid;
   logic                        ready;
   logic [cwd_pkg::GREEN_W-1:0] green;

   modport source (output valid, output green, input ready);
   modport sink (input valid, input green, output ready);
endinterface

interface cwd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cwd_pkg::GREY_W-1:0] grey;
   logic                       frame_last;

   modport source (output valid, output grey, output frame_last, input ready);
   modport sink (input valid, input grey, input frame_last, output ready);
endinterface

FILE: rtl/core/cwd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module cwd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cwd_csr.sv
// configuration registers on an apb-style port, plus clamped working values
// depends on cwd_pkg
module cwd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cwd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cwd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cwd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output cwd_pkg::cfg_type                   cfg
);
   import cwd_pkg::*;

   localparam logic [1:0] REG_SCALE  = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   logic [K_W-1:0]  scale_ff,  scale_in;
   logic [OW_W-1:0] width_ff,  width_in;
   logic [OH_W-1:0] height_ff, height_in;
   logic            wr;
   logic [1:0]      idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[3:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         unique case (idx)
            REG_SCALE:  scale_in  = csr_pwdata[K_W-1:0];
            REG_WIDTH:  width_in  = csr_pwdata[OW_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[OH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= K_W'(1);
         width_ff  <= OW_W'(64);
         height_ff <= OH_W'(64);
      end else begin
         scale_ff  <= scale_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_SCALE:  csr_prdata = CSR_DATA_W'(scale_ff);
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // zero acts as one, oversize values saturate
   always_comb begin
      if (scale_ff == '0) begin
         cfg.k = K_W'(1);
      end else if (scale_ff > K_W'(MAX_SCALE_QUARTER)) begin
         cfg.k = K_W'(MAX_SCALE_QUARTER);
      end else begin
         cfg.k = scale_ff;
      end
      if (width_ff == '0) begin
         cfg.width = OW_W'(1);
      end else if (width_ff > OW_W'(MAX_OUT_WIDTH)) begin
         cfg.width = OW_W'(MAX_OUT_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff == '0) begin
         cfg.height = OH_W'(1);
      end else if (height_ff > OH_W'(MAX_OUT_HEIGHT)) begin
         cfg.height = OH_W'(MAX_OUT_HEIGHT);
      end else begin
         cfg.height = height_ff;
      end
   end

endmodule

FILE: rtl/core/cwd_ctrl.sv
// controller: sequences pixel intake, column sum fetch and the divider
// depends on cwd_pkg and the assertion macro header
`include "central_window_downsampler_top_defines.svh"

module cwd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cwd_pkg::sts_type sts,
   output cwd_pkg::cmd_type cmd
);
   import cwd_pkg::*;

   state_type state_ff, state_in;
   logic      ready_w;
   logic      take_w;

   // a window-closing pixel waits while the previous result is still held
   assign ready_w = (state_ff == ST_RUN) && !(sts.emit_now && sts.out_full);
   assign take_w  = req_valid && ready_w;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (take_w && sts.in_win) begin
               if (!sts.direct) begin
                  state_in = ST_READ;
               end else if (sts.emit_now) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_READ: begin
            state_in = sts.emit_held ? ST_DIV : ST_RUN;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_ready = ready_w;
            cmd.take  = take_w;
            if (take_w && sts.in_win) begin
               if (sts.direct) begin
                  cmd.wr_now   = 1'b1;
                  cmd.div_load = sts.emit_now;
               end else begin
                  cmd.rd = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.wr_read  = 1'b1;
            cmd.div_load = sts.emit_held;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.out_load = sts.div_done;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   `CWD_ASSERT_NXT(a_read_one_cycle, clock, reset, state_ff == ST_READ, state_ff != ST_READ)
   `CWD_ASSERT_IMP(a_busy_no_intake, clock, reset, state_ff != ST_RUN, !req_ready)

endmodule

FILE: rtl/core/cwd_datapath.sv
// datapath: raster counters, column sum ram with forwarding register,
// serial divider and result register; depends on cwd_pkg, cwd_ram, macros
`include "central_window_downsampler_top_defines.svh"

module cwd_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  cwd_pkg::cfg_type            cfg,
   input  cwd_pkg::cmd_type            cmd,
   output cwd_pkg::sts_type            sts,
   input  logic [cwd_pkg::GREEN_W-1:0] green,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [cwd_pkg::GREY_W-1:0]  rsp_grey,
   output logic                        rsp_frame_last
);
   import cwd_pkg::*;

   function automatic logic [DIVS_W-1:0] ksq(input logic [K_W-1:0] kv);
      logic [2*K_W-1:0] p;
      p = kv * kv;
      return p[DIVS_W-1:0];
   endfunction

   // raster position
   logic [SUB_W-1:0] sub_col_ff, sub_col_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [SUB_W-1:0] sub_row_ff, sub_row_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   // pixel held across a ram fetch
   logic [GREEN_W-1:0] green_hold_ff;
   logic [COL_W-1:0]   col_hold_ff;
   logic               emit_hold_ff;
   logic               last_hold_ff;

   // copy of the most recently written column sum
   logic [SUM_W-1:0]         acc_ff;
   logic [COL_W-1:0]         acc_col_ff;
   logic                     acc_valid_ff;
   logic [MAX_OUT_WIDTH-1:0] valid_ff;

   // divider
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] divs_ff;
   logic [CNT_W-1:0]  dcnt_ff;
   logic [DIVS_W:0]   trial;
   logic              ge;

   // result register
   logic              out_valid_ff;
   logic [GREY_W-1:0] grey_ff;
   logic              last_ff;

   logic [SUB_W:0] k6, tile6, k3, k3m1, sc6, sr6;
   logic           in_x, in_y, first, emit_pt, hit;
   logic           sc_end, sr_end, col_end, row_end;
   logic [SUM_W-1:0] ram_rdata, mem_val, base_now, wr_sum;
   logic [COL_W-1:0] wr_col;
   logic             wr_en;

   assign k6    = (SUB_W+1)'(cfg.k);
   assign tile6 = {cfg.k, 2'b00};
   assign k3    = k6 + {k6[SUB_W-1:0], 1'b0};
   assign k3m1  = k3 - (SUB_W+1)'(1);
   assign sc6   = {1'b0, sub_col_ff};
   assign sr6   = {1'b0, sub_row_ff};

   assign in_x    = (sc6 >= k6) && (sc6 < k3);
   assign in_y    = (sr6 >= k6) && (sr6 < k3);
   assign first   = (sr6 == k6) && (sc6 == k6);
   assign emit_pt = (sr6 == k3m1) && (sc6 == k3m1);
   assign hit     = acc_valid_ff && (acc_col_ff == out_col_ff);

   assign sc_end  = (sc6 + (SUB_W+1)'(1)) >= tile6;
   assign sr_end  = (sr6 + (SUB_W+1)'(1)) >= tile6;
   assign col_end = ({1'b0, out_col_ff} + OW_W'(1)) >= cfg.width;
   assign row_end = ({1'b0, out_row_ff} + OH_W'(1)) >= cfg.height;

   assign sts.in_win    = in_x && in_y;
   assign sts.direct    = first || hit;
   assign sts.emit_now  = in_x && in_y && emit_pt;
   assign sts.emit_held = emit_hold_ff;
   assign sts.div_done  = (dcnt_ff == CNT_W'(DIVD_W - 1));
   assign sts.out_full  = out_valid_ff;

   // counter advance, wrapping at or beyond the last value
   always_comb begin
      sub_col_in = sub_col_ff;
      out_col_in = out_col_ff;
      sub_row_in = sub_row_ff;
      out_row_in = out_row_ff;
      if (cmd.take) begin
         if (sc_end) begin
            sub_col_in = '0;
            if (col_end) begin
               out_col_in = '0;
               if (sr_end) begin
                  sub_row_in = '0;
                  out_row_in = row_end ? '0 : out_row_ff + ROW_W'(1);
               end else begin
                  sub_row_in = sub_row_ff + SUB_W'(1);
               end
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end else begin
            sub_col_in = sub_col_ff + SUB_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_col_ff <= '0;
         out_col_ff <= '0;
         sub_row_ff <= '0;
         out_row_ff <= '0;
      end else begin
         sub_col_ff <= sub_col_in;
         out_col_ff <= out_col_in;
         sub_row_ff <= sub_row_in;
         out_row_ff <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         green_hold_ff <= green;
         col_hold_ff   <= out_col_ff;
         emit_hold_ff  <= sts.emit_now;
         last_hold_ff  <= row_end && col_end;
      end
   end

   // columns never written read as zero
   assign mem_val  = valid_ff[col_hold_ff] ? ram_rdata : '0;
   assign base_now = first ? '0 : acc_ff;
   assign wr_sum   = cmd.wr_read ? mem_val + SUM_W'(green_hold_ff)
                                 : base_now + SUM_W'(green);
   assign wr_col   = cmd.wr_read ? col_hold_ff : out_col_ff;
   assign wr_en    = cmd.wr_now || cmd.wr_read;

   cwd_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_OUT_WIDTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_col),
      .wr_data (wr_sum),
      .rd_en   (cmd.rd),
      .rd_addr (out_col_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else if (wr_en) begin
         acc_valid_ff     <= 1'b1;
         valid_ff[wr_col] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         acc_ff     <= wr_sum;
         acc_col_ff <= wr_col;
      end
   end

   // restoring division, one quotient bit a cycle
   assign trial  = {rem_ff, quo_ff[DIVD_W-1]};
   assign ge     = trial >= {1'b0, divs_ff};
   assign rem_in = ge ? DIVS_W'(trial - {1'b0, divs_ff}) : trial[DIVS_W-1:0];
   assign quo_in = {quo_ff[DIVD_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff  <= wr_sum[SUM_W-1:2];
         rem_ff  <= '0;
         divs_ff <= ksq(cfg.k);
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         dcnt_ff <= dcnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         grey_ff <= quo_in[GREY_W-1:0];
         last_ff <= last_hold_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_grey       = grey_ff;
   assign rsp_frame_last = last_ff;

   `CWD_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, !out_valid_ff)
   `CWD_ASSERT_IMP(a_acc_mirror, clock, reset, acc_valid_ff, valid_ff[acc_col_ff])

endmodule

FILE: rtl/core/central_window_downsampler_top.sv
// top level of the central window downsampler
// depends on cwd_pkg, cwd_if, cwd_csr, cwd_ctrl and cwd_datapath
//
// req_chan takes one green byte per item in raster order over a frame of
// (out_width * 4k) by (out_height * 4k) pixels, k being scale_quarter.
// rsp_chan gives one grey byte per 4k by 4k tile, the truncated mean of the
// tile's central 2k by 2k window, with frame_last set on the frame's final
// output. The csr_ port holds scale_quarter, out_width and out_height at
// byte addresses 0, 4 and 8; write them only while the block is idle.
// Throughput: one item a cycle outside the window and along a window row.
// A window row's first pixel, other than the window's first, has its column
// sum fetched from the column sum ram (registered read) unless the forwarding
// register holds it. The window's last pixel starts the serial divider, whose
// result is registered when it finishes; no item is taken during either.
// Reset zeroes the raster counters and the per-column valid flags, so every
// column sum reads as zero without a clearing pass; the block is ready in
// the first cycle after reset. A held result sits in the output register
// while later pixels keep flowing; only the next window-closing pixel waits
// for the receiver to take it.
module central_window_downsampler_top (
   input  logic                           clock,
   input  logic                           reset,
   cwd_req_if.sink                        req_chan,
   cwd_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cwd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cwd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cwd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import cwd_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   cwd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cwd_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .sts            (sts),
      .green          (req_chan.green),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_grey       (rsp_chan.grey),
      .rsp_frame_last (rsp_chan.frame_last)
   );

endmodule

FILE: tb/central_window_downsampler_top_tb.sv
// self-checking testbench for central_window_downsampler_top: drives green pixels and
// register writes, predicts each grey tile result and checks it against the rsp channel
// depends on cwd_pkg, cwd_if and the rtl of central_window_downsampler_top
module central_window_downsampler_top_tb;
   import cwd_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 24;

   typedef enum int {
      REG_SCALE_QUARTER = 0,
      REG_OUT_WIDTH     = 1,
      REG_OUT_HEIGHT    = 2
   } csr_index_t;

   typedef struct packed {
      logic [GREY_W-1:0] grey;
      logic              frame_last;
   } grey_pixel_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cwd_req_if req_chan ();
   cwd_rsp_if rsp_chan ();

   central_window_downsampler_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor copy of the registers and the raster position
   bit [K_W-1:0]  scale_reg  = 1;
   bit [OW_W-1:0] width_reg  = 64;
   bit [OH_W-1:0] height_reg = 64;
   int unsigned   window_sums [MAX_OUT_WIDTH];
   int unsigned   x_in_tile;
   int unsigned   y_in_tile;
   int unsigned   tile_col;
   int unsigned   tile_row;

   grey_pixel_t              pending_tiles [$];
   grey_pixel_t              predicted;
   grey_pixel_t              oldest;
   logic [GREEN_W-1:0]       scripted_greens [$];

   int  pixels_taken;
   int  tiles_predicted;
   int  tiles_checked;
   int  settings_written;
   int  error_count;
   int  cycle_count;
   int  stall_left;
   bit  steady;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int unsigned limit_to(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // one pixel through the window averager; returns 1 when a tile result comes out
   function automatic bit step_window(input logic [GREEN_W-1:0] g,
                                      output logic [GREY_W-1:0] grey,
                                      output logic last);
      int unsigned k, w, h, tile, col, quot;
      bit in_x, in_y, emit;
      k = limit_to(scale_reg, MAX_SCALE_QUARTER);
      w = limit_to(width_reg, MAX_OUT_WIDTH);
      h = limit_to(height_reg, MAX_OUT_HEIGHT);
      tile = 4 * k;
      emit = 1'b0;
      grey = '0;
      last = 1'b0;
      col = (tile_col >= MAX_OUT_WIDTH) ? 0 : tile_col;
      in_x = (x_in_tile >= k) && (x_in_tile < 3 * k);
      in_y = (y_in_tile >= k) && (y_in_tile < 3 * k);
      if (in_x && in_y) begin
         if (y_in_tile == k && x_in_tile == k) window_sums[col] = g;
         else window_sums[col] += g;
         if (y_in_tile == 3 * k - 1 && x_in_tile == 3 * k - 1) begin
            emit = 1'b1;
            quot = window_sums[col] / (4 * k * k);
            grey = quot[GREY_W-1:0];
            last = (tile_row + 1 >= h) && (tile_col + 1 >= w);
         end
      end
      if (x_in_tile + 1 >= tile) begin
         x_in_tile = 0;
         if (tile_col + 1 >= w) begin
            tile_col = 0;
            if (y_in_tile + 1 >= tile) begin
               y_in_tile = 0;
               tile_row = (tile_row + 1 >= h) ? 0 : tile_row + 1;
            end else begin
               y_in_tile++;
            end
         end else begin
            tile_col++;
         end
      end else begin
         x_in_tile++;
      end
      return emit;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      if (error_count < 50)
         $display("mismatch: %s, expected %0d, got %0d (cycle %0d)", what, want, got,
                  cycle_count);
      error_count++;
   endtask

   // pixels taken update the prediction before results are compared
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            pixels_taken++;
            if (step_window(req_chan.green, predicted.grey, predicted.frame_last)) begin
               pending_tiles.push_back(predicted);
               tiles_predicted++;
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_tiles.size() == 0) begin
               report_mismatch("grey result with no tile pending", -1, rsp_chan.grey);
            end else begin
               oldest = pending_tiles.pop_front();
               if (rsp_chan.grey !== oldest.grey)
                  report_mismatch("grey", oldest.grey, rsp_chan.grey);
               if (rsp_chan.frame_last !== oldest.frame_last)
                  report_mismatch("frame_last", oldest.frame_last, rsp_chan.frame_last);
               tiles_checked++;
            end
         end
      end
   end

   // receiver back-pressure: mostly short stalls, now and then a long one
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (steady || $urandom_range(0, 99) < 70) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= 1'b0;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // sends up to count pixels; a nonzero tile_target stops when tiles_predicted hits it
   task automatic feed_pixels(input int count, input int tile_target);
      int n, gap, r;
      bit stop;
      logic [GREEN_W-1:0] g;
      n = 0;
      stop = 1'b0;
      while (n < count && !stop) begin
         gap = pick_gap();
         if (gap > 0) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         if (tile_target > 0 && tiles_predicted >= tile_target) begin
            stop = 1'b1;
         end else begin
            if (scripted_greens.size() != 0) begin
               g = scripted_greens.pop_front();
            end else begin
               r = $urandom_range(0, 99);
               g = (r < 8) ? '0 : (r < 16) ? '1 : GREEN_W'($urandom_range(0, 255));
            end
            req_chan.valid <= 1'b1;
            req_chan.green <= g;
            do @(posedge clock); while (req_chan.ready !== 1'b1);
            n++;
         end
      end
      if (!stop) @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   // every pending tile has arrived, then the pipeline is given time to empty
   task automatic wait_quiet();
      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_t idx, input int unsigned value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_SCALE_QUARTER: scale_reg  = value[K_W-1:0];
         REG_OUT_WIDTH:     width_reg  = value[OW_W-1:0];
         REG_OUT_HEIGHT:    height_reg = value[OH_W-1:0];
         default: ;
      endcase
      settings_written++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // two tiles stacked in one column: window pixels against a contrasting border
   task automatic test_directed_frame();
      int r, c;
      bit win;
      write_reg(REG_SCALE_QUARTER, 1);
      write_reg(REG_OUT_WIDTH, 1);
      write_reg(REG_OUT_HEIGHT, 2);
      for (r = 0; r < 8; r++) begin
         for (c = 0; c < 4; c++) begin
            win = ((r % 4) == 1 || (r % 4) == 2) && (c == 1 || c == 2);
            if (r < 4) scripted_greens.push_back(win ? 8'd255 : 8'd0);
            else scripted_greens.push_back(win ? GREEN_W'((r - 5) * 2 + c - 1) : 8'd255);
         end
      end
      feed_pixels(32, 0);
   endtask

   // widen the frame mid-way through a tile row so one row emits all 128 columns
   task automatic test_wide_row();
      wait_quiet();
      feed_pixels(8, 0);
      wait_quiet();
      write_reg(REG_OUT_WIDTH, 128);
      write_reg(REG_OUT_HEIGHT, 1024);
      feed_pixels(264, 0);
      wait_quiet();
      // oversized values must clamp, so no tile past column 127
      write_reg(REG_OUT_WIDTH, 255);
      write_reg(REG_OUT_HEIGHT, 2047);
      feed_pixels(256, 0);
   endtask

   task automatic test_zero_settings();
      wait_quiet();
      write_reg(REG_SCALE_QUARTER, 0);
      write_reg(REG_OUT_WIDTH, 0);
      write_reg(REG_OUT_HEIGHT, 0);
      steady = 1'b1;
      feed_pixels(80, 0);
      steady = 1'b0;
      feed_pixels(80, 0);
   endtask

   task automatic test_random_settings();
      int start_pixels, start_tiles, n, phase;
      start_pixels = pixels_taken;
      start_tiles = tiles_checked;
      phase = 0;
      while (pixels_taken - start_pixels < 900 || tiles_checked - start_tiles < 48) begin
         wait_quiet();
         steady = ($urandom_range(0, 4) == 0);
         write_reg(REG_SCALE_QUARTER, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                                  : $urandom_range(1, 2));
         write_reg(REG_OUT_WIDTH, $urandom_range(0, 6));
         write_reg(REG_OUT_HEIGHT, $urandom_range(0, 3));
         n = $urandom_range(60, 150);
         feed_pixels(n / 2, 0);
         // first pass and at random: hold the sender until the results so far are out
         if (phase == 0 || $urandom_range(0, 2) == 0)
            while (pending_tiles.size() != 0) @(posedge clock);
         feed_pixels(n - n / 2, 0);
         phase++;
      end
      steady = 1'b0;
   endtask

   task automatic test_large_scale();
      wait_quiet();
      write_reg(REG_SCALE_QUARTER, 1);
      write_reg(REG_OUT_WIDTH, 1);
      write_reg(REG_OUT_HEIGHT, 1);
      // walk to a frame boundary so the big tile starts clean
      while (!(x_in_tile == 0 && y_in_tile == 0 && tile_col == 0 && tile_row == 0))
         feed_pixels(1, 0);
      wait_quiet();
      write_reg(REG_SCALE_QUARTER, 15);
      feed_pixels(1100, tiles_predicted + 1);
      wait_quiet();
      write_reg(REG_SCALE_QUARTER, 8);
      feed_pixels(264, 0);
      wait_quiet();
      write_reg(REG_SCALE_QUARTER, 1);
      feed_pixels(16, 0);
   endtask

   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.green = '0;
      rsp_chan.ready = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      steady         = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed_frame();
      test_wide_row();
      test_zero_settings();
      test_random_settings();
      test_large_scale();

      wait_quiet();
      $display("run covered %0d pixels, %0d grey tiles checked, %0d register writes",
               pixels_taken, tiles_checked, settings_written);
      $display("scales 1 to 8 with clamping, widths up to 128, frame ends, mid-frame changes");
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/cwd_pkg.sv
rtl/core/cwd_if.sv
rtl/core/cwd_ram.sv
rtl/core/cwd_csr.sv
rtl/core/cwd_ctrl.sv
rtl/core/cwd_datapath.sv
rtl/core/central_window_downsampler_top.sv
tb/central_window_downsampler_top_tb.sv
